// ===== rtl/htc_pkg.sv =====
// Shared types and constants for the Huffman tree codec.
// No dependencies; every other file of the block but htc_if refers to it.
package htc_pkg;

	localparam int MaxSymbols = 16;
	localparam int WeightBits = 16;
	localparam int NodeCount = 2 * MaxSymbols - 1;
	localparam int IdxW = $clog2(NodeCount + 1);
	localparam int LeafW = $clog2(MaxSymbols + 1);
	localparam int SymW = 8;
	localparam int WInW = 16;
	localparam int NodeWW = 20;
	localparam int CodeW = 15;
	localparam int LenW = 4;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_BUILD = 2'd1,
		OP_ENCODE = 2'd2,
		OP_DECODE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_VALUE = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [SymW-1:0] symbol_in;
		logic [WInW-1:0] weight_in;
		logic code_bit;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [SymW-1:0] symbol_out;
		logic [CodeW-1:0] code_value;
		logic [LenW-1:0] code_length;
		logic [NodeWW-1:0] root_weight;
	} out_item_t;

	// Classified command passed from the front to the back.
	typedef struct packed {
		op_t op;
		logic err;
		logic [SymW-1:0] sym;
		logic [NodeWW-1:0] weight;
		logic bit_in;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_MERGE,
		BK_FIND,
		BK_WALK,
		BK_OUT
	} bk_state_t;

endpackage

// ===== rtl/htc_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is given by the instantiating scope.
interface htc_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/htc_front.sv =====
// Front part: accepts items, checks them against leaf count and built flag.
// Depends on htc_pkg and htc_if.
module htc_front (
	input logic clk,
	input logic arst_n,
	htc_if.sink in_ch,
	output htc_pkg::cmd_t cmd,
	output logic cmd_valid,
	input logic cmd_ready
);

	logic [htc_pkg::LeafW-1:0] leaf_cnt_q;
	logic built_q;
	htc_pkg::in_item_t it;
	logic xfer;

	assign it = in_ch.data;
	assign in_ch.ready = cmd_ready;
	assign cmd_valid = in_ch.valid;
	assign xfer = in_ch.valid && cmd_ready;

	// Classify the item; errors are decided here from front-side state.
	always_comb begin
		cmd.op = htc_pkg::op_t'(it.operation);
		cmd.sym = it.symbol_in;
		cmd.weight = htc_pkg::NodeWW'(it.weight_in[htc_pkg::WeightBits-1:0]);
		cmd.bit_in = it.code_bit;
		unique case (cmd.op)
			htc_pkg::OP_LOAD: cmd.err = (leaf_cnt_q == htc_pkg::LeafW'(htc_pkg::MaxSymbols));
			htc_pkg::OP_BUILD: cmd.err = (leaf_cnt_q < htc_pkg::LeafW'(2));
			default: cmd.err = !built_q;
		endcase
	end

	// Leaf count and built flag follow the accepted items in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_cnt_q <= '0;
			built_q <= 1'b0;
		end else if (xfer && !cmd.err) begin
			if (cmd.op == htc_pkg::OP_LOAD) begin
				leaf_cnt_q <= leaf_cnt_q + 1'b1;
				built_q <= 1'b0;
			end else if (cmd.op == htc_pkg::OP_BUILD) begin
				built_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		leaf_cnt_q <= htc_pkg::LeafW'(htc_pkg::MaxSymbols)) else $error("leaf count overflow");
	a_built_needs: assert property (@(posedge clk) disable iff (!arst_n)
		built_q |-> leaf_cnt_q >= htc_pkg::LeafW'(2)) else $error("built with few leaves");
	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !cmd.err && cmd.op == htc_pkg::OP_LOAD) |=> !built_q)
		else $error("load left tree built");
`endif

endmodule

// ===== rtl/htc_queue.sv =====
// Short command queue between the front and the back.
// Depends on htc_pkg.
module htc_queue (
	input logic clk,
	input logic arst_n,
	input htc_pkg::cmd_t wr_data,
	input logic wr_valid,
	output logic wr_ready,
	output htc_pkg::cmd_t rd_data,
	output logic rd_valid,
	input logic rd_ready
);

	htc_pkg::cmd_t mem_q [htc_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != 2'(htc_pkg::QDepth));
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(htc_pkg::QDepth)) else $error("queue overflow");
	a_ptr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wp_q != rp_q)) else $error("pointer mismatch");
	a_empty_eq: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wp_q == rp_q)) else $error("pointer mismatch on empty");
`endif

endmodule

// ===== rtl/htc_back.sv =====
// Back part: node table, build scan, encode walk, decode step, output register.
// Depends on htc_pkg and htc_if.
module htc_back (
	input logic clk,
	input logic arst_n,
	input htc_pkg::cmd_t cmd,
	input logic cmd_valid,
	output logic cmd_ready,
	htc_if.source out_ch
);

	localparam int IW = htc_pkg::IdxW;
	localparam int LW = htc_pkg::LeafW;

	logic [htc_pkg::NodeWW-1:0] wt_q [htc_pkg::NodeCount];
	logic [IW-1:0] lft_q [htc_pkg::NodeCount];
	logic [IW-1:0] rgt_q [htc_pkg::NodeCount];
	logic [IW-1:0] par_q [htc_pkg::NodeCount];
	logic used_q [htc_pkg::NodeCount];
	logic [htc_pkg::SymW-1:0] lsym_q [htc_pkg::MaxSymbols];

	logic [LW-1:0] nleaf_q;
	logic [IW-1:0] pos_q;
	htc_pkg::bk_state_t st_q, st_d;
	logic [IW-1:0] top_q, j_q, a_q, b_q;
	logic ha_q, hb_q;
	logic [htc_pkg::SymW-1:0] sym_q;
	logic [htc_pkg::CodeW-1:0] code_q;
	logic [htc_pkg::LenW-1:0] len_q;
	htc_pkg::out_item_t res_q;
	logic full_q;

	logic [IW-1:0] root;
	logic take;
	logic [IW-1:0] nxt;
	htc_pkg::out_item_t res_new;

	assign root = IW'({nleaf_q, 1'b0}) - IW'(2);
	assign out_ch.valid = full_q;
	assign out_ch.data = res_q;
	assign cmd_ready = (st_q == htc_pkg::BK_IDLE) && !full_q;
	assign take = cmd_valid && cmd_ready;
	assign nxt = cmd.bit_in ? rgt_q[pos_q] : lft_q[pos_q];

	// Next state of the sequencer.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			htc_pkg::BK_IDLE: begin
				if (take && !cmd.err) begin
					if (cmd.op == htc_pkg::OP_BUILD) st_d = htc_pkg::BK_SCAN;
					else if (cmd.op == htc_pkg::OP_ENCODE) st_d = htc_pkg::BK_FIND;
				end
			end
			htc_pkg::BK_SCAN: if (j_q == top_q) st_d = htc_pkg::BK_MERGE;
			htc_pkg::BK_MERGE: begin
				if (top_q == root) st_d = htc_pkg::BK_OUT;
				else st_d = htc_pkg::BK_SCAN;
			end
			htc_pkg::BK_FIND: begin
				if (j_q == IW'(nleaf_q)) st_d = htc_pkg::BK_OUT;
				else if (lsym_q[j_q[LW-2:0]] == sym_q) st_d = htc_pkg::BK_WALK;
			end
			htc_pkg::BK_WALK: if (a_q == root) st_d = htc_pkg::BK_OUT;
			htc_pkg::BK_OUT: if (!full_q) st_d = htc_pkg::BK_IDLE;
			default: st_d = htc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= htc_pkg::BK_IDLE;
		else st_q <= st_d;
	end

	// Result of a transfer as it is taken; build and encode fill theirs in later.
	always_comb begin
		res_new = '0;
		res_new.status = htc_pkg::ST_ERROR;
		if (!cmd.err) begin
			unique case (cmd.op)
				htc_pkg::OP_LOAD: res_new.status = htc_pkg::ST_OK;
				htc_pkg::OP_DECODE: begin
					if (nxt < IW'(nleaf_q)) begin
						res_new.status = htc_pkg::ST_VALUE;
						res_new.symbol_out = lsym_q[nxt[LW-2:0]];
					end else begin
						res_new.status = htc_pkg::ST_OK;
					end
				end
				default: ;
			endcase
		end
	end

	// Control registers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nleaf_q <= '0;
			pos_q <= '0;
			full_q <= 1'b0;
		end else begin
			if (full_q && out_ch.ready) full_q <= 1'b0;
			if (take) begin
				if (cmd.err) begin
					full_q <= 1'b1;
				end else if (cmd.op == htc_pkg::OP_LOAD) begin
					nleaf_q <= nleaf_q + 1'b1;
					pos_q <= '0;
					full_q <= 1'b1;
				end else if (cmd.op == htc_pkg::OP_DECODE) begin
					full_q <= 1'b1;
					if (nxt < IW'(nleaf_q)) pos_q <= root;
					else pos_q <= nxt;
				end
			end
			if (st_q == htc_pkg::BK_MERGE && top_q == root) pos_q <= root;
			if (st_q == htc_pkg::BK_OUT && !full_q) full_q <= 1'b1;
		end
	end

	// Datapath: table writes, scan and walk registers, result forming.
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_new;
			sym_q <= cmd.sym;
			j_q <= '0;
			ha_q <= 1'b0;
			hb_q <= 1'b0;
			top_q <= IW'(nleaf_q);
			code_q <= '0;
			len_q <= '0;
			for (int i = 0; i < htc_pkg::MaxSymbols; i++) begin
				if (!cmd.err && cmd.op == htc_pkg::OP_BUILD && i < int'(nleaf_q)) used_q[i] <= 1'b0;
			end
			if (!cmd.err && cmd.op == htc_pkg::OP_LOAD) begin
				wt_q[nleaf_q] <= cmd.weight;
				used_q[nleaf_q] <= 1'b0;
				lsym_q[nleaf_q[LW-2:0]] <= cmd.sym;
			end
		end
		unique case (st_q)
			htc_pkg::BK_SCAN: begin
				if (j_q != top_q) begin
					if (!used_q[j_q]) begin
						if (!ha_q || wt_q[j_q] < wt_q[a_q]) begin
							b_q <= a_q;
							hb_q <= ha_q;
							a_q <= j_q;
							ha_q <= 1'b1;
						end else if (!hb_q || wt_q[j_q] < wt_q[b_q]) begin
							b_q <= j_q;
							hb_q <= 1'b1;
						end
					end
					j_q <= j_q + 1'b1;
				end
			end
			htc_pkg::BK_MERGE: begin
				wt_q[top_q] <= wt_q[a_q] + wt_q[b_q];
				lft_q[top_q] <= a_q;
				rgt_q[top_q] <= b_q;
				used_q[top_q] <= 1'b0;
				par_q[a_q] <= top_q;
				par_q[b_q] <= top_q;
				used_q[a_q] <= 1'b1;
				used_q[b_q] <= 1'b1;
				j_q <= '0;
				ha_q <= 1'b0;
				hb_q <= 1'b0;
				top_q <= top_q + 1'b1;
				if (top_q == root) begin
					res_q <= '{status: htc_pkg::ST_VALUE, symbol_out: '0, code_value: '0,
						code_length: '0, root_weight: wt_q[a_q] + wt_q[b_q]};
				end
			end
			htc_pkg::BK_FIND: begin
				if (j_q != IW'(nleaf_q)) begin
					if (lsym_q[j_q[LW-2:0]] == sym_q) a_q <= j_q;
					else j_q <= j_q + 1'b1;
				end
			end
			htc_pkg::BK_WALK: begin
				if (a_q != root) begin
					if (rgt_q[par_q[a_q]] == a_q) code_q[len_q] <= 1'b1;
					len_q <= len_q + 1'b1;
					a_q <= par_q[a_q];
				end else begin
					res_q <= '{status: htc_pkg::ST_VALUE, symbol_out: '0, code_value: code_q,
						code_length: len_q, root_weight: '0};
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> st_q == htc_pkg::BK_IDLE) else $error("item taken while busy");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < IW'(htc_pkg::NodeCount)) else $error("decode position out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !out_ch.ready) |=> full_q) else $error("result dropped");
`endif

endmodule

// ===== rtl/huffman_tree_codec.sv =====
// Top level of the Huffman tree codec: front, command queue and back.
// Depends on htc_pkg, htc_if, htc_front, htc_queue and htc_back.
//
//   channel   direction   payload
//   in_ch     sink        operation, symbol_in, weight_in, code_bit
//   out_ch    source      status, symbol_out, code_value, code_length, root_weight
//
// The back sequencer handles one item at a time.
// Build runs a serial minimum scan over the nodes before each merge.
// Encode runs a symbol search over the leaves, then a parent walk that adds one code bit per step.
// Reset clears leaf count, built flag, decode position and all handshake state.
// A stalled result holds the back, and the two-entry queue then fills and stalls the input.
module huffman_tree_codec (
	input logic clk,
	input logic arst_n,
	htc_if.sink in_ch,
	htc_if.source out_ch
);

	htc_pkg::cmd_t f_cmd, b_cmd;
	logic f_valid, f_ready, b_valid, b_ready;

	htc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	htc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(b_cmd), .rd_valid(b_valid), .rd_ready(b_ready)
	);

	htc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(b_cmd), .cmd_valid(b_valid), .cmd_ready(b_ready), .out_ch(out_ch)
	);

endmodule
